// ===== src/json_string_unescape_macros.svh =====
// assertion macros for the json string unescaper
`ifndef JSON_STRING_UNESCAPE_MACROS_SVH
`define JSON_STRING_UNESCAPE_MACROS_SVH

`ifndef SYNTHESIS
`define JSU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define JSU_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define JSU_ASSERT(lbl, prop, msg)
`define JSU_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== src/jsu_pkg.sv =====
// shared types, codes and helper functions of the json string unescaper
package jsu_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [3:0] ERR_NONE     = 4'd0;
	localparam logic [3:0] ERR_NO_QUOTE = 4'd1;
	localparam logic [3:0] ERR_ESCAPE   = 4'd2;
	localparam logic [3:0] ERR_HEX      = 4'd3;
	localparam logic [3:0] ERR_NO_LOW   = 4'd4;
	localparam logic [3:0] ERR_BAD_LOW  = 4'd5;
	localparam logic [3:0] ERR_LONE_LOW = 4'd6;
	localparam logic [3:0] ERR_CONTROL  = 4'd7;
	localparam logic [3:0] ERR_OPEN_END = 4'd8;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	typedef enum logic [3:0] {
		M_QUOTE = 4'd0,
		M_STR   = 4'd1,
		M_ESC   = 4'd2,
		M_HEX1  = 4'd3,
		M_BSL   = 4'd4,
		M_LU    = 4'd5,
		M_HEX2  = 4'd6
	} mode_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      len;
	} utf8_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      nbytes;
		logic            has_term;
		logic [1:0]      kind;
		logic [3:0]      err;
	} job_t;

	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	function automatic utf8_t utf8_encode(input logic [20:0] cp);
		utf8_t r;
		r.bytes = '0;
		if (cp <= 21'h7F) begin
			r.len = 3'd1;
			r.bytes[0] = {1'b0, cp[6:0]};
		end else if (cp <= 21'h7FF) begin
			r.len = 3'd2;
			r.bytes[0] = {3'b110, cp[10:6]};
			r.bytes[1] = {2'b10, cp[5:0]};
		end else if (cp <= 21'hFFFF) begin
			r.len = 3'd3;
			r.bytes[0] = {4'b1110, cp[15:12]};
			r.bytes[1] = {2'b10, cp[11:6]};
			r.bytes[2] = {2'b10, cp[5:0]};
		end else begin
			r.len = 3'd4;
			r.bytes[0] = {5'b11110, cp[20:18]};
			r.bytes[1] = {2'b10, cp[17:12]};
			r.bytes[2] = {2'b10, cp[11:6]};
			r.bytes[3] = {2'b10, cp[5:0]};
		end
		return r;
	endfunction

endpackage

// ===== src/jsu_front.sv =====
// parser front: takes one text byte per cycle while the job queue is not full and turns it into at most one result job
module jsu_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [7:0]     in_byte,
	input  logic           in_end,
	input  logic           queue_full,
	output logic           in_ready,
	output logic           push,
	output jsu_pkg::job_t  job
);

	jsu_pkg::mode_t mode_q, mode_d;
	logic [15:0] accum_q, accum_d;
	logic [9:0]  high_q, high_d;
	logic [1:0]  digit_q, digit_d;

	logic        acc;
	logic [4:0]  hex;
	logic [15:0] unit;
	logic        is_high, is_low, digits_done;
	logic [20:0] cp_pair;
	jsu_pkg::utf8_t enc_single, enc_pair;
	logic [7:0]  esc_byte;
	logic        esc_simple;
	jsu_pkg::job_t job_c;

	assign in_ready    = !queue_full;
	assign acc         = in_valid && in_ready;
	assign hex         = jsu_pkg::hex_decode(in_byte);
	assign unit        = {accum_q[11:0], hex[3:0]};
	assign is_high     = unit[15:10] == 6'b110110;
	assign is_low      = unit[15:10] == 6'b110111;
	assign digits_done = digit_q == 2'd3;
	assign cp_pair     = 21'h10000 + {1'b0, high_q, unit[9:0]};
	assign enc_single  = jsu_pkg::utf8_encode({5'd0, unit});
	assign enc_pair    = jsu_pkg::utf8_encode(cp_pair);

	always_comb begin
		esc_simple = 1'b1;
		esc_byte   = in_byte;
		case (in_byte)
			8'h22, 8'h5C, 8'h2F: esc_byte = in_byte;
			8'h62: esc_byte = 8'h08;
			8'h66: esc_byte = 8'h0C;
			8'h6E: esc_byte = 8'h0A;
			8'h72: esc_byte = 8'h0D;
			8'h74: esc_byte = 8'h09;
			default: esc_simple = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		mode_d  = mode_q;
		accum_d = accum_q;
		high_d  = high_q;
		digit_d = digit_q;
		unique case (mode_q)
			jsu_pkg::M_QUOTE: begin
				mode_d = (in_byte == jsu_pkg::CH_QUOTE) ? jsu_pkg::M_STR : jsu_pkg::M_QUOTE;
			end
			jsu_pkg::M_STR: begin
				if (in_byte == jsu_pkg::CH_QUOTE) mode_d = jsu_pkg::M_QUOTE;
				else if (in_byte == jsu_pkg::CH_BSL) mode_d = jsu_pkg::M_ESC;
				else if (in_byte < 8'h20) mode_d = jsu_pkg::M_QUOTE;
			end
			jsu_pkg::M_ESC: begin
				if (esc_simple) mode_d = jsu_pkg::M_STR;
				else if (in_byte == 8'h75) begin
					mode_d  = jsu_pkg::M_HEX1;
					accum_d = '0;
					digit_d = '0;
				end else mode_d = jsu_pkg::M_QUOTE;
			end
			jsu_pkg::M_HEX1, jsu_pkg::M_HEX2: begin
				if (!hex[4]) mode_d = jsu_pkg::M_QUOTE;
				else begin
					accum_d = unit;
					digit_d = digit_q + 2'd1;
					if (digits_done) begin
						if (mode_q == jsu_pkg::M_HEX1) begin
							if (is_high) begin
								high_d = unit[9:0];
								mode_d = jsu_pkg::M_BSL;
							end else if (is_low) mode_d = jsu_pkg::M_QUOTE;
							else mode_d = jsu_pkg::M_STR;
						end else begin
							mode_d = is_low ? jsu_pkg::M_STR : jsu_pkg::M_QUOTE;
						end
					end
				end
			end
			jsu_pkg::M_BSL: begin
				mode_d = (in_byte == jsu_pkg::CH_BSL) ? jsu_pkg::M_LU : jsu_pkg::M_QUOTE;
			end
			jsu_pkg::M_LU: begin
				if (in_byte == 8'h75) begin
					mode_d  = jsu_pkg::M_HEX2;
					accum_d = '0;
					digit_d = '0;
				end else mode_d = jsu_pkg::M_QUOTE;
			end
			default: mode_d = jsu_pkg::M_QUOTE;
		endcase
		if (in_end) mode_d = jsu_pkg::M_QUOTE;
	end

	// job for this byte
	always_comb begin
		job_c          = '0;
		job_c.kind     = jsu_pkg::KIND_ERROR;
		job_c.err      = jsu_pkg::ERR_NONE;
		unique case (mode_q)
			jsu_pkg::M_QUOTE: begin
				if (in_byte != jsu_pkg::CH_QUOTE) begin
					job_c.has_term = 1'b1;
					job_c.err      = jsu_pkg::ERR_NO_QUOTE;
				end
			end
			jsu_pkg::M_STR: begin
				if (in_byte == jsu_pkg::CH_QUOTE) begin
					job_c.has_term = 1'b1;
					job_c.kind     = jsu_pkg::KIND_DONE;
				end else if (in_byte == jsu_pkg::CH_BSL) begin
					job_c.has_term = 1'b0;
				end else if (in_byte < 8'h20) begin
					job_c.has_term = 1'b1;
					job_c.err      = jsu_pkg::ERR_CONTROL;
				end else begin
					job_c.nbytes   = 3'd1;
					job_c.bytes[0] = in_byte;
				end
			end
			jsu_pkg::M_ESC: begin
				if (esc_simple) begin
					job_c.nbytes   = 3'd1;
					job_c.bytes[0] = esc_byte;
				end else if (in_byte != 8'h75) begin
					job_c.has_term = 1'b1;
					job_c.err      = jsu_pkg::ERR_ESCAPE;
				end
			end
			jsu_pkg::M_HEX1: begin
				if (!hex[4]) begin
					job_c.has_term = 1'b1;
					job_c.err      = jsu_pkg::ERR_HEX;
				end else if (digits_done && is_low) begin
					job_c.has_term = 1'b1;
					job_c.err      = jsu_pkg::ERR_LONE_LOW;
				end else if (digits_done && !is_high) begin
					job_c.nbytes = enc_single.len;
					job_c.bytes  = enc_single.bytes;
				end
			end
			jsu_pkg::M_HEX2: begin
				if (!hex[4]) begin
					job_c.has_term = 1'b1;
					job_c.err      = jsu_pkg::ERR_HEX;
				end else if (digits_done && !is_low) begin
					job_c.has_term = 1'b1;
					job_c.err      = jsu_pkg::ERR_BAD_LOW;
				end else if (digits_done) begin
					job_c.nbytes = enc_pair.len;
					job_c.bytes  = enc_pair.bytes;
				end
			end
			jsu_pkg::M_BSL: begin
				if (in_byte != jsu_pkg::CH_BSL) begin
					job_c.has_term = 1'b1;
					job_c.err      = jsu_pkg::ERR_NO_LOW;
				end
			end
			jsu_pkg::M_LU: begin
				if (in_byte != 8'h75) begin
					job_c.has_term = 1'b1;
					job_c.err      = jsu_pkg::ERR_NO_LOW;
				end
			end
			default: begin
				job_c.has_term = 1'b1;
				job_c.err      = jsu_pkg::ERR_NO_QUOTE;
			end
		endcase
		// text ran out with the string still open
		if (in_end && !job_c.has_term && mode_q != jsu_pkg::M_QUOTE) begin
			job_c.has_term = 1'b1;
			job_c.kind     = jsu_pkg::KIND_ERROR;
			job_c.err      = jsu_pkg::ERR_OPEN_END;
		end
		if (in_end && mode_q == jsu_pkg::M_QUOTE && in_byte == jsu_pkg::CH_QUOTE) begin
			job_c.has_term = 1'b1;
			job_c.kind     = jsu_pkg::KIND_ERROR;
			job_c.err      = jsu_pkg::ERR_OPEN_END;
		end
	end

	assign job  = job_c;
	assign push = acc && (job_c.has_term || job_c.nbytes != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= jsu_pkg::M_QUOTE;
			accum_q <= '0;
			high_q  <= '0;
			digit_q <= '0;
		end else if (acc) begin
			mode_q  <= mode_d;
			accum_q <= accum_d;
			high_q  <= high_d;
			digit_q <= digit_d;
		end
	end

endmodule

// ===== src/jsu_queue.sv =====
// short job queue between parser front and output back
module jsu_queue #(
	parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  jsu_pkg::job_t  push_job,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output jsu_pkg::job_t  head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jsu_pkg::job_t mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign full      = count_q == CW'(DEPTH);
	assign not_empty = count_q != '0;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			if (push && !pop) count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

`include "json_string_unescape_macros.svh"

	`JSU_ASSERT(a_no_push_full, !(push && full && !pop), "push into a full job queue")
	`JSU_ASSERT(a_no_pop_empty, !(pop && !not_empty), "pop from an empty job queue")
	`JSU_ASSERT(a_count_in_range, count_q <= CW'(DEPTH), "job queue count beyond depth")

endmodule

// ===== src/jsu_back.sv =====
// output back: expands each job into result words through an output register
module jsu_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  jsu_pkg::job_t  q_job,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic [1:0]     out_kind,
	output logic [3:0]     out_err,
	output logic           out_last
);

	jsu_pkg::job_t job_q;
	logic [2:0]    pos_q;
	logic          busy_q;
	logic          valid_q;
	logic [7:0]    byte_q;
	logic [1:0]    kind_q;
	logic [3:0]    err_q;
	logic          last_q;

	logic       out_load, emit, last, is_data;
	logic [2:0] total;

	assign total    = job_q.nbytes + {2'd0, job_q.has_term};
	assign out_load = !valid_q || out_ready;
	assign emit     = busy_q && out_load;
	assign last     = pos_q == total - 3'd1;
	assign is_data  = pos_q < job_q.nbytes;
	assign pop      = q_valid && (!busy_q || (emit && last));

	always_ff @(posedge clk) begin
		if (pop) job_q <= q_job;
		if (emit) begin
			byte_q <= is_data ? job_q.bytes[pos_q[1:0]] : 8'd0;
			kind_q <= is_data ? jsu_pkg::KIND_DATA : job_q.kind;
			err_q  <= is_data ? jsu_pkg::ERR_NONE : job_q.err;
			last_q <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			pos_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
			end else if (emit && last) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				pos_q <= pos_q + 3'd1;
			end
			if (emit) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_kind  = kind_q;
	assign out_err   = err_q;
	assign out_last  = last_q;

`include "json_string_unescape_macros.svh"

	`JSU_ASSERT(a_pos_in_job, busy_q |-> (pos_q < total), "result index beyond job")
	`JSU_ASSERT(a_term_is_last, (emit && !is_data) |-> last, "done or error word not last")
	`JSU_ASSERT(a_job_nonempty, pop |-> (q_job.has_term || q_job.nbytes != 3'd0),
		"empty job in queue")

endmodule

// ===== src/json_string_unescape.sv =====
// top level of the json string unescaper with utf-8 output
//
// channel  dir  tdata                     tuser    tlast
// s_*      in   [7:0] text byte           -        end of available text
// m_*      out  [7:0] byte, [11:8] error  [1:0]    last word of this input byte
//                                          kind
//
// one text byte is taken per cycle while the job queue has room
// each byte yields zero to five words, emitted one per cycle from the back while m_tready is high
// a word passes through the job queue, the job register and the output register of the back
// a stalled m_tready fills the queue, then s_tready drops
// arst_n clears the parser to expecting an opening quote and empties the queue
module json_string_unescape #(
	parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte
	input  logic        s_tlast,   // in_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // out_byte, error_code, zero pad
	output logic [1:0]  m_tuser,   // kind
	output logic        m_tlast    // out_last
);

	jsu_pkg::job_t push_job, head_job;
	logic push, pop, full, not_empty;
	logic [7:0] out_byte;
	logic [3:0] out_err;

	jsu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_byte    (s_tdata),
		.in_end     (s_tlast),
		.queue_full (full),
		.in_ready   (s_tready),
		.push       (push),
		.job        (push_job)
	);

	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head_job)
	);

	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (not_empty),
		.q_job     (head_job),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (out_byte),
		.out_kind  (m_tuser),
		.out_err   (out_err),
		.out_last  (m_tlast)
	);

	assign m_tdata = {4'd0, out_err, out_byte};

endmodule
